FILE: rtl/pvfe_pkg.sv
// Shared types and constants of the varint field extractor.
package pvfe_pkg;

    // Field and byte layout
    localparam int FIELD_W       = 5;
    localparam int VALUE_W       = 8;
    localparam int PAYLOAD_BITS  = 7;
    localparam int WIRE_W        = 3;

    typedef logic [FIELD_W-1:0] field_t;
    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [WIRE_W-1:0]  wire_type_t;

    // Wire types understood by the parser
    localparam wire_type_t WT_VARINT = 3'd0;
    localparam wire_type_t WT_LENGTH = 3'd2;

    // Parse phase codes
    localparam int PHASE_W = 2;
    localparam logic [PHASE_W-1:0] PH_TAG   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_VALUE = 2'd1;
    localparam logic [PHASE_W-1:0] PH_LEN   = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FIELD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_FIELD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NESTED_FIELD = 2'd2;

    // Configuration reset values
    localparam field_t FIRST_FIELD_RST  = 5'd1;
    localparam field_t SECOND_FIELD_RST = 5'd2;
    localparam field_t NESTED_FIELD_RST = 5'd2;

endpackage

FILE: rtl/pvfe_byte_if.sv
// Byte channel carrying the encoded message.
interface pvfe_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: rtl/pvfe_result_if.sv
// Result channel carrying the parse status and captured values.
interface pvfe_result_if;
    logic       valid;
    logic       ready;
    logic       ok;
    logic [7:0] first_value;
    logic [7:0] second_value;

    modport source (output valid, output ok, output first_value, output second_value,
                    input ready);
    modport sink   (input valid, input ok, input first_value, input second_value,
                    output ready);
endinterface

FILE: rtl/pvfe_varint_gather.sv
// Varint accumulation: places one 7-bit group into the length-wide accumulator.
module pvfe_varint_gather
    import pvfe_pkg::*;
#(
    parameter int LENGTH_BITS = 16
)
(
    input  logic [PAYLOAD_BITS-1:0]                  payload,
    input  logic [$clog2((LENGTH_BITS+6)/7+1)-1:0]   cnt,
    input  logic [LENGTH_BITS-1:0]                   acc,
    input  logic                                     hi,
    output logic [$clog2((LENGTH_BITS+6)/7+1)-1:0]   cnt_next,
    output logic [LENGTH_BITS-1:0]                   acc_next,
    output logic                                     hi_next
);

    // groups needed before every payload bit lands above the length field
    localparam int CNT_MAX = (LENGTH_BITS + 6) / 7;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);
    localparam int SH_W    = PAYLOAD_BITS * (CNT_MAX + 1);
    localparam int SHA_W   = $clog2(SH_W);

    logic [SH_W-1:0]  placed;
    logic [SHA_W-1:0] shamt;

    // position the group; anything at or above LENGTH_BITS only marks the value too wide
    assign shamt    = SHA_W'(int'(cnt) * PAYLOAD_BITS);
    assign placed   = SH_W'(payload) << shamt;
    assign acc_next = acc | placed[LENGTH_BITS-1:0];
    assign hi_next  = hi | (|placed[SH_W-1:LENGTH_BITS]);
    assign cnt_next = (cnt == CNT_W'(CNT_MAX)) ? cnt : cnt + CNT_W'(1);

endmodule

FILE: rtl/protobuf_varint_field_extractor.sv
// Top level: byte-serial protobuf-style parser that captures two varint fields.
// Throughput: one byte transaction per cycle while the result side is not stalled.
// The result is registered and appears in the cycle after the transaction carrying last_byte.
// Every byte is parsed in one pass through the tag/varint/region logic below.
// Reset (rst_n, asynchronous, active low) restores the field numbers 1, 2 and 2
// and clears the parser at once; no clearing pass follows.
module protobuf_varint_field_extractor
    import pvfe_pkg::*;
#(
    parameter int MAX_DEPTH   = 4,
    parameter int LENGTH_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [FIELD_W-1:0]    cfg_data,
    pvfe_byte_if.sink             msg,
    pvfe_result_if.source         res
);

    localparam int DW     = $clog2(MAX_DEPTH + 1);
    localparam int IW     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CNT_W  = $clog2((LENGTH_BITS + 6) / 7 + 1);

    // configuration
    field_t first_field_reg, second_field_reg, nested_field_reg;

    // parser state
    logic [PHASE_W-1:0]     phase_reg, phase_next;
    logic [DW-1:0]          depth_reg, depth_next, depth_mid;
    logic [LENGTH_BITS-1:0] rem_reg [MAX_DEPTH];
    logic [LENGTH_BITS-1:0] rem_next [MAX_DEPTH];
    logic [MAX_DEPTH-1:0]   skip_reg, skip_next;
    logic [LENGTH_BITS-1:0] acc_reg, acc_next;
    logic                   hi_reg, hi_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    field_t                 field_reg, field_next;
    value_t                 first_reg, first_next, second_reg, second_next;
    value_t                 tent_first_reg, tent_first_next;
    value_t                 tent_second_reg, tent_second_next;
    logic                   tent_first_vld_reg, tent_first_vld_next;
    logic                   tent_second_vld_reg, tent_second_vld_next;
    logic                   top_error_reg, top_error_next;

    // result register
    logic   out_valid_reg, out_valid_next;
    logic   out_ok_reg;
    value_t out_first_reg, out_second_reg;

    // per-byte working signals
    logic                   accept;
    logic                   nested, room, lvl_err;
    logic [IW-1:0]          top_idx, child_idx;
    logic [LENGTH_BITS-1:0] top_rem, rem_dec;
    logic [LENGTH_BITS-1:0] g_acc;
    logic                   g_hi;
    logic [CNT_W-1:0]       g_cnt;
    wire_type_t             wire_type;
    value_t                 vbyte;

    // handshake
    assign accept    = msg.valid && msg.ready;
    assign msg.ready = !out_valid_reg || res.ready;

    assign res.valid        = out_valid_reg;
    assign res.ok           = out_ok_reg;
    assign res.first_value  = out_first_reg;
    assign res.second_value = out_second_reg;

    // varint group placement
    pvfe_varint_gather #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_gather (
        .payload  (msg.data_byte[PAYLOAD_BITS-1:0]),
        .cnt      (cnt_reg),
        .acc      (acc_reg),
        .hi       (hi_reg),
        .cnt_next (g_cnt),
        .acc_next (g_acc),
        .hi_next  (g_hi)
    );

    assign nested    = depth_reg != '0;
    assign top_idx   = IW'(depth_reg - DW'(1));
    assign child_idx = IW'(depth_reg);
    assign top_rem   = rem_reg[top_idx];
    assign rem_dec   = top_rem - LENGTH_BITS'(1);
    assign room      = !nested || (rem_dec != '0);
    assign wire_type = msg.data_byte[WIRE_W-1:0];
    assign vbyte     = g_acc[VALUE_W-1:0];

    // one byte through the parser, then close every finished region
    always_comb
    begin
        phase_next           = phase_reg;
        depth_mid            = depth_reg;
        rem_next             = rem_reg;
        skip_next            = skip_reg;
        acc_next             = acc_reg;
        hi_next              = hi_reg;
        cnt_next             = cnt_reg;
        field_next           = field_reg;
        first_next           = first_reg;
        second_next          = second_reg;
        tent_first_next      = tent_first_reg;
        tent_second_next     = tent_second_reg;
        tent_first_vld_next  = tent_first_vld_reg;
        tent_second_vld_next = tent_second_vld_reg;
        top_error_next       = top_error_reg;
        lvl_err              = 1'b0;
        depth_next           = depth_reg;

        if (!top_error_reg)
        begin
            if (nested && skip_reg[top_idx])
            begin
                // skipped region just counts down
                if (top_rem != '0)
                    rem_next[top_idx] = rem_dec;
            end
            else
            begin
                if (nested)
                    rem_next[top_idx] = rem_dec;

                if (phase_reg == PH_TAG)
                begin
                    // tag byte: field number and wire type
                    field_next = msg.data_byte[7:3];
                    acc_next   = '0;
                    hi_next    = 1'b0;
                    cnt_next   = '0;
                    if (wire_type == WT_VARINT)
                    begin
                        phase_next = PH_VALUE;
                        lvl_err    = !room;
                    end
                    else if (wire_type == WT_LENGTH)
                    begin
                        phase_next = PH_LEN;
                        lvl_err    = !room;
                    end
                    else
                        lvl_err = 1'b1;
                end
                else
                begin
                    acc_next = g_acc;
                    hi_next  = g_hi;
                    cnt_next = g_cnt;
                    if (msg.data_byte[7])
                        lvl_err = !room;
                    else if (phase_reg == PH_VALUE)
                    begin
                        // completed varint value
                        phase_next = PH_TAG;
                        if (field_reg == first_field_reg)
                        begin
                            if (!nested)
                                first_next = vbyte;
                            else
                            begin
                                tent_first_next     = vbyte;
                                tent_first_vld_next = 1'b1;
                            end
                        end
                        if (field_reg == second_field_reg)
                        begin
                            if (!nested)
                                second_next = vbyte;
                            else
                            begin
                                tent_second_next     = vbyte;
                                tent_second_vld_next = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        // completed length: open a region if it is non-empty and fits
                        phase_next = PH_TAG;
                        if (g_hi)
                            lvl_err = 1'b1;
                        else if (nested && (g_acc > rem_dec))
                            lvl_err = 1'b1;
                        else
                        begin
                            if (nested)
                                rem_next[top_idx] = rem_dec - g_acc;
                            if (g_acc != '0)
                            begin
                                if (int'(depth_reg) >= MAX_DEPTH)
                                    lvl_err = 1'b1;
                                else
                                begin
                                    rem_next[child_idx]  = g_acc;
                                    skip_next[child_idx] =
                                        !((field_reg == nested_field_reg) &&
                                          (g_acc > LENGTH_BITS'(1)) &&
                                          (int'(depth_reg) + 1 < MAX_DEPTH));
                                    depth_mid = depth_reg + DW'(1);
                                end
                            end
                        end
                    end
                end

                // error at the current level
                if (lvl_err)
                begin
                    phase_next = PH_TAG;
                    if (!nested)
                        top_error_next = 1'b1;
                    else
                        skip_next[top_idx] = 1'b1;
                end
            end

            // pop every region whose count reached zero
            depth_next = depth_mid;
            for (int i = MAX_DEPTH - 1; i >= 0; i--)
            begin
                if ((depth_next == DW'(i + 1)) && (rem_next[i] == '0))
                    depth_next = DW'(i);
            end

            // top-level region complete: tentative values become visible
            if ((depth_mid != '0) && (depth_next == '0))
            begin
                if (tent_first_vld_next)
                    first_next = tent_first_next;
                if (tent_second_vld_next)
                    second_next = tent_second_next;
                tent_first_vld_next  = 1'b0;
                tent_second_vld_next = 1'b0;
                tent_first_next      = '0;
                tent_second_next     = '0;
            end
        end
    end

    // result register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept && msg.last_byte)
            out_valid_next = 1'b1;
        else if (res.ready)
            out_valid_next = 1'b0;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_field_reg  <= FIRST_FIELD_RST;
            second_field_reg <= SECOND_FIELD_RST;
            nested_field_reg <= NESTED_FIELD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FIRST_FIELD:  first_field_reg  <= cfg_data;
                CFG_SECOND_FIELD: second_field_reg <= cfg_data;
                CFG_NESTED_FIELD: nested_field_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // parser state; a message end returns it to the cleared state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_TAG;
            depth_reg           <= '0;
            for (int i = 0; i < MAX_DEPTH; i++)
                rem_reg[i] <= '0;
            skip_reg            <= '0;
            acc_reg             <= '0;
            hi_reg              <= 1'b0;
            cnt_reg             <= '0;
            field_reg           <= '0;
            first_reg           <= '0;
            second_reg          <= '0;
            tent_first_reg      <= '0;
            tent_second_reg     <= '0;
            tent_first_vld_reg  <= 1'b0;
            tent_second_vld_reg <= 1'b0;
            top_error_reg       <= 1'b0;
        end
        else if (accept)
        begin
            if (msg.last_byte)
            begin
                phase_reg           <= PH_TAG;
                depth_reg           <= '0;
                for (int i = 0; i < MAX_DEPTH; i++)
                    rem_reg[i] <= '0;
                skip_reg            <= '0;
                acc_reg             <= '0;
                hi_reg              <= 1'b0;
                cnt_reg             <= '0;
                field_reg           <= '0;
                first_reg           <= '0;
                second_reg          <= '0;
                tent_first_reg      <= '0;
                tent_second_reg     <= '0;
                tent_first_vld_reg  <= 1'b0;
                tent_second_vld_reg <= 1'b0;
                top_error_reg       <= 1'b0;
            end
            else
            begin
                phase_reg           <= phase_next;
                depth_reg           <= depth_next;
                rem_reg             <= rem_next;
                skip_reg            <= skip_next;
                acc_reg             <= acc_next;
                hi_reg              <= hi_next;
                cnt_reg             <= cnt_next;
                field_reg           <= field_next;
                first_reg           <= first_next;
                second_reg          <= second_next;
                tent_first_reg      <= tent_first_next;
                tent_second_reg     <= tent_second_next;
                tent_first_vld_reg  <= tent_first_vld_next;
                tent_second_vld_reg <= tent_second_vld_next;
                top_error_reg       <= top_error_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && msg.last_byte)
        begin
            out_ok_reg     <= !top_error_next && (depth_next == '0) &&
                              (phase_next == PH_TAG);
            out_first_reg  <= first_next;
            out_second_reg <= second_next;
        end
    end

endmodule

FILE: rtl/pvfe_checker.sv
// Port-level checks of the extractor, bound to the top level.
module pvfe_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       msg_valid,
    input logic       msg_ready,
    input logic       msg_last,
    input logic       res_valid,
    input logic       res_ready,
    input logic       res_ok,
    input logic [7:0] res_first,
    input logic [7:0] res_second
);

    // a last-byte transaction always gives a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && msg_ready && msg_last |=> res_valid)
        else $error("pvfe: no result after last byte");

    // a fresh result only follows a last-byte transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(res_valid) && res_valid |-> $past(msg_valid && msg_ready && msg_last))
        else $error("pvfe: result without last byte");

    // a non-last byte with the result slot free leaves no result behind
    assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && msg_ready && !msg_last && (!res_valid || res_ready) |=> !res_valid)
        else $error("pvfe: spurious result");

    // the byte side is held off while a result is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |-> !msg_ready)
        else $error("pvfe: byte taken while result stalled");

    // a stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_ok) && $stable(res_first) &&
                                    $stable(res_second))
        else $error("pvfe: stalled result changed");

endmodule

bind protobuf_varint_field_extractor pvfe_checker u_pvfe_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .msg_valid  (msg.valid),
    .msg_ready  (msg.ready),
    .msg_last   (msg.last_byte),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .res_ok     (res.ok),
    .res_first  (res.first_value),
    .res_second (res.second_value)
);
